// File: rtl/core/lifcd_pkg.sv
// ----------------------------------------------------------------------------
// lifcd_pkg
// Shared types and constants of the conductance-jump integrate-and-fire neuron.
// ----------------------------------------------------------------------------
`default_nettype none

package lifcd_pkg;

  localparam int RING_W = 18;
  localparam int MAG_W  = 19;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [RING_W-1:0] RING_MAX = 18'h3FFFF;

  // reset values of the configuration registers
  localparam logic [15:0]        DECAY_RST   = 16'd65100;
  localparam logic signed [15:0] EREV_RST    = 16'sd17920;
  localparam logic signed [15:0] IREV_RST    = -16'sd2560;
  localparam logic signed [15:0] THRESH_RST  = 16'sd3840;
  localparam logic signed [15:0] RESETLV_RST = 16'sd0;
  localparam logic [15:0]        REFR_RST    = 16'd20;
  localparam logic signed [15:0] REST_RST    = -16'sd17920;

  typedef enum logic [2:0] {
    REG_DECAY   = 3'd0,
    REG_EREV    = 3'd1,
    REG_IREV    = 3'd2,
    REG_THRESH  = 3'd3,
    REG_RESETLV = 3'd4,
    REG_REFR    = 3'd5,
    REG_REST    = 3'd6
  } lifcd_reg_t;

  typedef struct packed {
    logic [15:0]        decay_factor;
    logic signed [15:0] excitatory_reversal;
    logic signed [15:0] inhibitory_reversal;
    logic signed [15:0] threshold_level;
    logic signed [15:0] reset_level;
    logic [15:0]        refractory_steps;
    logic signed [15:0] resting_level;
  } lifcd_cfg_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic             is_tick;
    logic             excit;
    logic [MAG_W-1:0] mag;
  } lifcd_item_t;

endpackage

`default_nettype wire

// File: rtl/core/lifcd_ram.sv
// ----------------------------------------------------------------------------
// lifcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lifcd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lifcd_front.sv
// ----------------------------------------------------------------------------
// lifcd_front
// Accepts items, works out ring, magnitude and delay slot offset, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lifcd_front #(
  parameter int DELAY_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           req_type,
  input  wire logic signed [15:0]             weight,
  input  wire logic [3:0]                     multiplicity,
  input  wire logic [3:0]                     delay_ticks,
  output logic                                q_valid,
  input  wire logic                           q_pop,
  output lifcd_pkg::lifcd_item_t              q_item,
  output logic [$clog2(DELAY_SLOTS)-1:0]      q_dmod
);

  localparam int PW     = $clog2(DELAY_SLOTS);
  localparam int MW     = lifcd_pkg::MAG_W;
  localparam int DW     = ((PW > 4) ? PW : 4) + 1;
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam logic [DW-1:0] SLOTS_W = DW'(DELAY_SLOTS);

  logic                         accept;
  logic [15:0]                  abs_w;
  logic [lifcd_pkg::MAG_W-1:0]  prod;
  logic [DW-1:0]                d;
  lifcd_pkg::lifcd_item_t       entry;
  logic [PW-1:0]                dmod;

  logic [CW-1:0]                count;
  logic [QAW-1:0]               wr_ptr;
  logic [QAW-1:0]               rd_ptr;
  lifcd_pkg::lifcd_item_t       item_mem [QDEPTH];
  logic [PW-1:0]                dmod_mem [QDEPTH];

  assign full    = (count == CW'(QDEPTH));
  assign accept  = push && !full;
  assign q_valid = (count != '0);
  assign q_item  = item_mem[rd_ptr];
  assign q_dmod  = dmod_mem[rd_ptr];

  assign abs_w = weight[15] ? 16'(-weight) : 16'(weight);
  assign prod  = MW'(abs_w) * MW'(multiplicity);

  // delay reduced modulo the ring length by repeated subtraction
  always_comb begin
    d = DW'(delay_ticks);
    for (int i = 0; i < 8; i++) begin
      if (d >= SLOTS_W) begin
        d = d - SLOTS_W;
      end
    end
    dmod = d[PW-1:0];
  end

  always_comb begin
    entry.is_tick = req_type;
    entry.excit   = !weight[15] && (weight != 16'sd0);
    entry.mag     = prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= QAW'(wr_ptr + 1'b1);
      end
      if (q_pop) begin
        rd_ptr <= QAW'(rd_ptr + 1'b1);
      end
      if (accept && !q_pop) begin
        count <= CW'(count + 1'b1);
      end else if (!accept && q_pop) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mem[wr_ptr] <= entry;
      dmod_mem[wr_ptr] <= dmod;
    end
  end

  // the back end only takes an item that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: rtl/core/lifcd_back.sv
// ----------------------------------------------------------------------------
// lifcd_back
// Executes queued items: ring read-modify-write for arrivals, and the leak,
// conductance jump, threshold and refractory update for ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module lifcd_back #(
  parameter int DELAY_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lifcd_pkg::lifcd_cfg_t          cfg,
  input  wire logic                           q_valid,
  output logic                                q_pop,
  input  wire lifcd_pkg::lifcd_item_t         q_item,
  input  wire logic [$clog2(DELAY_SLOTS)-1:0] q_dmod,
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                fired,
  output logic signed [15:0]                  membrane_potential
);

  localparam int PW = $clog2(DELAY_SLOTS);
  localparam int RW = lifcd_pkg::RING_W;
  localparam int MW = lifcd_pkg::MAG_W;
  localparam logic [PW:0] SLOTS_W = (PW + 1)'(DELAY_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ARRIVE = 7'b0000010,
    S_DECAY  = 7'b0000100,
    S_VSAT   = 7'b0001000,
    S_MULE   = 7'b0010000,
    S_MULI   = 7'b0100000,
    S_FINISH = 7'b1000000
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [25:0] x);
    if (x > 26'sd32767) begin
      return 16'sd32767;
    end else if (x < -26'sd32768) begin
      return -16'sd32768;
    end else begin
      return x[15:0];
    end
  endfunction

  back_state_t              state;
  logic [PW-1:0]            pos;
  logic [15:0]              refr;
  logic signed [15:0]       pot;
  logic [DELAY_SLOTS-1:0]   evalid;
  logic [DELAY_SLOTS-1:0]   ivalid;
  logic                     active;
  logic                     hit_e;
  logic                     hit_i;
  logic [PW-1:0]            slot_q;
  logic                     excit_q;
  logic [MW-1:0]            mag_q;
  logic [RW-1:0]            ge_q;
  logic [RW-1:0]            gi_q;
  logic signed [32:0]       prod_d;
  logic signed [15:0]       v_q;
  logic signed [35:0]       pe_q;
  logic signed [35:0]       pi_q;
  logic                     out_valid;

  logic [PW:0]              slot_sum;
  logic [PW-1:0]            slot;
  logic [PW-1:0]            raddr;
  logic                     e_re;
  logic                     i_re;
  logic                     e_we;
  logic                     i_we;
  logic [RW-1:0]            e_rdata;
  logic [RW-1:0]            i_rdata;
  logic [RW-1:0]            old_val;
  logic [RW+1:0]            sum_w;
  logic [RW-1:0]            wdata;
  logic signed [32:0]       dsh;
  logic signed [16:0]       diff_e;
  logic signed [16:0]       diff_i;
  logic signed [36:0]       acc;
  logic signed [36:0]       acc_r;
  logic signed [25:0]       cand;
  logic signed [15:0]       pot_cand;
  logic signed [15:0]       pot_final;
  logic signed [16:0]       abs_pot;
  logic                     fire;
  logic                     out_free;

  assign q_pop = (state == S_IDLE) && q_valid;

  // target slot of an arrival
  assign slot_sum = {1'b0, pos} + {1'b0, q_dmod};
  assign slot     = (slot_sum >= SLOTS_W) ? PW'(slot_sum - SLOTS_W) : slot_sum[PW-1:0];
  assign raddr    = q_item.is_tick ? pos : slot;

  assign e_re = q_pop && (q_item.is_tick || q_item.excit);
  assign i_re = q_pop && (q_item.is_tick || !q_item.excit);
  assign e_we = (state == S_ARRIVE) && excit_q;
  assign i_we = (state == S_ARRIVE) && !excit_q;

  // an entry not written since its last read counts as zero
  assign old_val = excit_q ? (hit_e ? e_rdata : '0) : (hit_i ? i_rdata : '0);
  assign sum_w   = {2'b00, old_val} + {1'b0, mag_q};
  assign wdata   = (sum_w > {2'b00, lifcd_pkg::RING_MAX}) ? lifcd_pkg::RING_MAX : sum_w[RW-1:0];

  lifcd_ram #(.WIDTH(RW), .DEPTH(DELAY_SLOTS)) u_exc_ring (
    .clk   (clk),
    .we    (e_we),
    .waddr (slot_q),
    .wdata (wdata),
    .re    (e_re),
    .raddr (raddr),
    .rdata (e_rdata)
  );

  lifcd_ram #(.WIDTH(RW), .DEPTH(DELAY_SLOTS)) u_inh_ring (
    .clk   (clk),
    .we    (i_we),
    .waddr (slot_q),
    .wdata (wdata),
    .re    (i_re),
    .raddr (raddr),
    .rdata (i_rdata)
  );

  // tick arithmetic
  assign dsh    = (prod_d + 33'sd32768) >>> 16;
  assign diff_e = 17'($signed(cfg.excitatory_reversal)) - 17'(v_q);
  assign diff_i = 17'($signed(cfg.inhibitory_reversal)) - 17'(v_q);
  assign acc    = 37'(pe_q) + 37'(pi_q);
  assign acc_r  = (acc + 37'sd2048) >>> 12;
  assign cand   = $signed(acc_r[25:0]) + 26'(v_q);

  assign pot_cand  = active ? sat16(cand) : pot;
  assign fire      = (pot_cand >= $signed(cfg.threshold_level));
  assign pot_final = fire ? $signed(cfg.reset_level) : pot_cand;
  assign abs_pot   = 17'(pot_final) + 17'($signed(cfg.resting_level));
  assign out_free  = !out_valid || pop;

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      refr      <= '0;
      pot       <= '0;
      evalid    <= '0;
      ivalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.is_tick) begin
              evalid[pos] <= 1'b0;
              ivalid[pos] <= 1'b0;
              pos         <= (pos == PW'(DELAY_SLOTS - 1)) ? '0 : PW'(pos + 1'b1);
              if (refr != 16'd0) begin
                refr  <= refr - 16'd1;
                state <= S_FINISH;
              end else begin
                state <= S_DECAY;
              end
            end else begin
              state <= S_ARRIVE;
            end
          end
        end
        S_ARRIVE: begin
          if (excit_q) begin
            evalid[slot_q] <= 1'b1;
          end else begin
            ivalid[slot_q] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_DECAY: state <= S_VSAT;
        S_VSAT:  state <= S_MULE;
        S_MULE:  state <= S_MULI;
        S_MULI:  state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            pot <= pot_final;
            if (fire) begin
              refr <= cfg.refractory_steps;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hit_e   <= evalid[raddr];
      hit_i   <= ivalid[raddr];
      slot_q  <= slot;
      excit_q <= q_item.excit;
      mag_q   <= q_item.mag;
      active  <= (refr == 16'd0);
    end
    if (state == S_DECAY) begin
      ge_q   <= hit_e ? e_rdata : '0;
      gi_q   <= hit_i ? i_rdata : '0;
      prod_d <= 33'($signed({1'b0, cfg.decay_factor})) * 33'(pot);
    end
    if (state == S_VSAT) begin
      v_q <= sat16(26'(dsh));
    end
    if (state == S_MULE) begin
      pe_q <= 36'(diff_e) * 36'($signed({1'b0, ge_q}));
    end
    if (state == S_MULI) begin
      pi_q <= 36'(diff_i) * 36'($signed({1'b0, gi_q}));
    end
    if ((state == S_FINISH) && out_free) begin
      fired              <= fire;
      membrane_potential <= sat16(26'(abs_pot));
    end
  end

  a_tick_clears_slot: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.is_tick) |=> (!evalid[$past(pos)] && !ivalid[$past(pos)]))
    else $error("ring slot still marked after tick read");

  a_fire_reloads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && out_free && fire) |=>
      (refr == $past(cfg.refractory_steps)) && out_valid && fired)
    else $error("refractory counter not reloaded on spike");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result produced outside tick completion");

endmodule

`default_nettype wire

// File: rtl/core/conductance_delta_lif_neuron.sv
// ----------------------------------------------------------------------------
// conductance_delta_lif_neuron
// Leaky integrate-and-fire neuron with conductance-jump synapses and
// excitatory/inhibitory delay rings, Q8.8 mV potentials.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  -------   ---------------------   -------------------------------------------
//  input     push / full             req_type, weight, multiplicity, delay_ticks
//  result    pop / empty             fired, membrane_potential
//  config    psel/penable/pready     paddr, pwdata, pwrite, prdata
//
//  an arrival passes through the back end as a ring read, then an add and write
//  a tick steps through the chained decay, saturate, excitatory multiply and
//  inhibitory multiply states before finish; a refractory tick skips to finish
//  the front queues two items, so input is taken while the back end works
//  a finished tick waits in the result register; the back end stalls only
//  when a second tick completes before the first result is popped
//  reset clears the rings through per-slot valid bits, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module conductance_delta_lif_neuron #(
  parameter int DELAY_SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          req_type,
  input  wire logic signed [15:0]            weight,
  input  wire logic [3:0]                    multiplicity,
  input  wire logic [3:0]                    delay_ticks,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               fired,
  output logic signed [15:0]                 membrane_potential,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lifcd_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [lifcd_pkg::CFG_DW-1:0]  pwdata,
  output logic [lifcd_pkg::CFG_DW-1:0]       prdata,
  output logic                               pready
);

  localparam int PW = $clog2(DELAY_SLOTS);

  lifcd_pkg::lifcd_cfg_t  cfg;
  lifcd_pkg::lifcd_reg_t  reg_idx;
  logic                   cfg_wr;
  logic                   q_valid;
  logic                   q_pop;
  lifcd_pkg::lifcd_item_t q_item;
  logic [PW-1:0]          q_dmod;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = lifcd_pkg::lifcd_reg_t'(paddr[lifcd_pkg::CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_factor        <= lifcd_pkg::DECAY_RST;
      cfg.excitatory_reversal <= lifcd_pkg::EREV_RST;
      cfg.inhibitory_reversal <= lifcd_pkg::IREV_RST;
      cfg.threshold_level     <= lifcd_pkg::THRESH_RST;
      cfg.reset_level         <= lifcd_pkg::RESETLV_RST;
      cfg.refractory_steps    <= lifcd_pkg::REFR_RST;
      cfg.resting_level       <= lifcd_pkg::REST_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        lifcd_pkg::REG_DECAY:   cfg.decay_factor        <= pwdata[15:0];
        lifcd_pkg::REG_EREV:    cfg.excitatory_reversal <= pwdata[15:0];
        lifcd_pkg::REG_IREV:    cfg.inhibitory_reversal <= pwdata[15:0];
        lifcd_pkg::REG_THRESH:  cfg.threshold_level     <= pwdata[15:0];
        lifcd_pkg::REG_RESETLV: cfg.reset_level         <= pwdata[15:0];
        lifcd_pkg::REG_REFR:    cfg.refractory_steps    <= pwdata[15:0];
        lifcd_pkg::REG_REST:    cfg.resting_level       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lifcd_pkg::REG_DECAY:   prdata = {16'h0000, cfg.decay_factor};
      lifcd_pkg::REG_EREV:    prdata = {16'h0000, cfg.excitatory_reversal};
      lifcd_pkg::REG_IREV:    prdata = {16'h0000, cfg.inhibitory_reversal};
      lifcd_pkg::REG_THRESH:  prdata = {16'h0000, cfg.threshold_level};
      lifcd_pkg::REG_RESETLV: prdata = {16'h0000, cfg.reset_level};
      lifcd_pkg::REG_REFR:    prdata = {16'h0000, cfg.refractory_steps};
      lifcd_pkg::REG_REST:    prdata = {16'h0000, cfg.resting_level};
      default:                prdata = '0;
    endcase
  end

  lifcd_front #(.DELAY_SLOTS(DELAY_SLOTS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .weight       (weight),
    .multiplicity (multiplicity),
    .delay_ticks  (delay_ticks),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .q_dmod       (q_dmod)
  );

  lifcd_back #(.DELAY_SLOTS(DELAY_SLOTS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_item             (q_item),
    .q_dmod             (q_dmod),
    .empty              (empty),
    .pop                (pop),
    .fired              (fired),
    .membrane_potential (membrane_potential)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the conductance-jump integrate-and-fire neuron:
// a queue-fed driver and a monitor run against an in-bench neuron predictor,
// over directed arrivals and ticks, then random phases under several settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int RING_SLOTS   = 16;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int PHASE_ITEMS  = 215;
  localparam int REPORT_MAX   = 10;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic ARRIVAL = 1'b0;
  localparam logic TICK    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] weight;
    logic [3:0]         multiplicity;
    logic [3:0]         delay_ticks;
  } nrn_item_t;

  typedef struct packed {
    logic               fired;
    logic signed [15:0] vm;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic req_type = 1'b0;
  logic signed [15:0] weight = '0;
  logic [3:0] multiplicity = '0;
  logic [3:0] delay_ticks = '0;
  logic empty;
  logic pop = 1'b0;
  logic fired;
  logic signed [15:0] membrane_potential;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lifcd_pkg::CFG_AW-1:0] paddr = '0;
  logic [lifcd_pkg::CFG_DW-1:0] pwdata = '0;
  logic [lifcd_pkg::CFG_DW-1:0] prdata;
  logic pready;

  conductance_delta_lif_neuron #(.DELAY_SLOTS(RING_SLOTS)) i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .weight(weight), .multiplicity(multiplicity), .delay_ticks(delay_ticks),
    .empty(empty), .pop(pop), .fired(fired), .membrane_potential(membrane_potential),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [15:0]        m_decay, m_refr;
  logic signed [15:0] m_erev, m_irev, m_thresh, m_reset, m_rest;
  longint             vm_rel;
  logic [15:0]        refr_left;
  longint             exc_ring [RING_SLOTS];
  longint             inh_ring [RING_SLOTS];
  logic [3:0]         ring_pos;

  nrn_item_t    stim_items [$];
  tick_result_t expected_ticks [$];
  nrn_item_t    offered;
  int items_queued = 0;
  int items_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  logic steady = 1'b0;

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clamp_ring(longint v);
    return (v > longint'(lifcd_pkg::RING_MAX)) ? longint'(lifcd_pkg::RING_MAX) : v;
  endfunction

  task automatic predict_neuron(input nrn_item_t it);
    longint mag, ge, gi, v, acc;
    logic [3:0] slot;
    tick_result_t res;
    if (it.req_type == ARRIVAL) begin
      slot = ring_pos + it.delay_ticks;
      mag = longint'(it.weight);
      if (mag < 0) mag = -mag;
      mag = mag * longint'(it.multiplicity);
      if (it.weight > 0) exc_ring[slot] = clamp_ring(exc_ring[slot] + mag);
      else inh_ring[slot] = clamp_ring(inh_ring[slot] + mag);
    end else begin
      ge = exc_ring[ring_pos];
      gi = inh_ring[ring_pos];
      exc_ring[ring_pos] = 0;
      inh_ring[ring_pos] = 0;
      ring_pos = ring_pos + 4'd1;
      if (refr_left == 16'd0) begin
        // leak, then jump towards both reversal potentials
        v = clamp16((longint'(m_decay) * vm_rel + 32768) >>> 16);
        acc = (longint'(m_erev) - v) * ge + (longint'(m_irev) - v) * gi;
        vm_rel = clamp16(v + ((acc + 2048) >>> 12));
      end else begin
        refr_left = refr_left - 16'd1;
      end
      res.fired = 1'b0;
      if (vm_rel >= longint'(m_thresh)) begin
        refr_left = m_refr;
        vm_rel = longint'(m_reset);
        res.fired = 1'b1;
      end
      res.vm = 16'(clamp16(vm_rel + longint'(m_rest)));
      expected_ticks.push_back(res);
    end
  endtask

  task automatic add_item(input logic rt, input logic [15:0] w, input logic [3:0] m,
                          input logic [3:0] d);
    nrn_item_t it;
    it.req_type = rt;
    it.weight = w;
    it.multiplicity = m;
    it.delay_ticks = d;
    stim_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_random(input int count);
    int pick;
    logic [15:0] w;
    logic [3:0] m;
    repeat (count) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) w = 16'h7FFF;
      else if (pick == 1) w = 16'h8000;
      else if (pick == 2) w = 16'h0000;
      else if (pick <= 10) w = 16'($urandom_range(0, 1500));
      else if (pick <= 17) w = 16'(-$urandom_range(0, 1500));
      else w = 16'($urandom);
      m = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
      add_item(($urandom_range(0, 99) < 40) ? TICK : ARRIVAL, w, m, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lifcd_pkg::REG_DECAY:   m_decay = val;
      lifcd_pkg::REG_EREV:    m_erev = val;
      lifcd_pkg::REG_IREV:    m_irev = val;
      lifcd_pkg::REG_THRESH:  m_thresh = val;
      lifcd_pkg::REG_RESETLV: m_reset = val;
      lifcd_pkg::REG_REFR:    m_refr = val;
      lifcd_pkg::REG_REST:    m_rest = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] d, input logic [15:0] e,
                               input logic [15:0] i, input logic [15:0] t,
                               input logic [15:0] r, input logic [15:0] f,
                               input logic [15:0] s);
    cfg_write(lifcd_pkg::REG_DECAY, d);
    cfg_write(lifcd_pkg::REG_EREV, e);
    cfg_write(lifcd_pkg::REG_IREV, i);
    cfg_write(lifcd_pkg::REG_THRESH, t);
    cfg_write(lifcd_pkg::REG_RESETLV, r);
    cfg_write(lifcd_pkg::REG_REFR, f);
    cfg_write(lifcd_pkg::REG_REST, s);
  endtask

  // wait for every item to go in and every tick result to come out
  task automatic drain();
    do @(posedge clk); while (items_taken != items_queued || expected_ticks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_neuron(offered);
        items_taken++;
      end
      if (!(push && full)) begin
        if (stim_items.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
          offered = stim_items.pop_front();
          push <= 1'b1;
          req_type <= offered.req_type;
          weight <= offered.weight;
          multiplicity <= offered.multiplicity;
          delay_ticks <= offered.delay_ticks;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_ticks.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("result with no tick waiting: fired=%0b vm=%0d", fired,
                     membrane_potential);
        end else begin
          want = expected_ticks.pop_front();
          if (fired !== want.fired || membrane_potential !== want.vm) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("result %0d: expected fired=%0b vm=%0d, got fired=%0b vm=%0d",
                       results_seen, want.fired, want.vm, fired, membrane_potential);
          end
        end
      end
      // one long hold-off so the neuron backs up and raises full
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    m_decay = lifcd_pkg::DECAY_RST;
    m_erev = lifcd_pkg::EREV_RST;
    m_irev = lifcd_pkg::IREV_RST;
    m_thresh = lifcd_pkg::THRESH_RST;
    m_reset = lifcd_pkg::RESETLV_RST;
    m_refr = lifcd_pkg::REFR_RST;
    m_rest = lifcd_pkg::REST_RST;
    vm_rel = 0;
    refr_left = '0;
    ring_pos = '0;
    for (int k = 0; k < RING_SLOTS; k++) begin
      exc_ring[k] = 0;
      inh_ring[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // saturating both rings, zero weight, zero multiplicity, zero delay
    add_item(ARRIVAL, 16'h7FFF, 4'd15, 4'd1);
    add_item(ARRIVAL, 16'h8000, 4'd15, 4'd1);
    add_item(ARRIVAL, 16'h0000, 4'd7, 4'd2);
    add_item(ARRIVAL, 16'd1200, 4'd0, 4'd2);
    add_item(ARRIVAL, 16'd800, 4'd1, 4'd0);
    // tick fields are ignored
    add_item(TICK, 16'h8000, 4'd15, 4'd15);
    add_item(TICK, 16'h7FFF, 4'd0, 4'd0);
    add_item(TICK, 16'h0000, 4'd5, 4'd9);
    add_item(TICK, 16'hFFFF, 4'd15, 4'd0);
    add_item(ARRIVAL, 16'd1, 4'd1, 4'd15);
    add_item(ARRIVAL, 16'hFFFF, 4'd15, 4'd15);
    add_item(ARRIVAL, 16'd5000, 4'd3, 4'd8);
    repeat (13) add_item(TICK, 16'h0000, 4'd0, 4'd0);
    drain();

    apply_setting(16'd65100, 16'd17920, -16'sd2560, 16'd3840, 16'd0, 16'd3, -16'sd17920);
    cfg_write(REG_UNUSED, 16'($urandom));
    add_random(PHASE_ITEMS);
    drain();

    // upper extremes: fires only from a saturated potential
    apply_setting(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'h7FFF);
    add_random(PHASE_ITEMS);
    drain();

    // reset level above threshold: refires on every tick
    apply_setting(16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000);
    add_random(PHASE_ITEMS);
    drain();

    apply_setting(16'($urandom_range(55000, 65535)), 16'($urandom_range(4000, 32767)),
                  16'(-$urandom_range(0, 8000)), 16'($urandom_range(500, 8000)),
                  16'(-$urandom_range(0, 2000)), 16'($urandom_range(0, 8)),
                  16'($urandom));
    steady <= 1'b1;
    add_random(PHASE_ITEMS);
    drain();
    steady <= 1'b0;

    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    add_random(PHASE_ITEMS);
    drain();

    apply_setting(16'd60000, 16'd20000, -16'sd4000, 16'd1000, -16'sd1000, 16'd1,
                  -16'sd17920);
    add_random(PHASE_ITEMS);
    drain();

    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
